[rtl/image_chunk_reassembly_control_macros.svh]
// Assertion macros for the image chunk reassembly control block.
// Both macros clock on i_clk and are disabled while i_rst_n is low.
`ifndef IMAGE_CHUNK_REASSEMBLY_CONTROL_MACROS_SVH
`define IMAGE_CHUNK_REASSEMBLY_CONTROL_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define ICRC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("icrc: same-cycle check failed");
// next-cycle implication
`define ICRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("icrc: next-cycle check failed");
`else
`define ICRC_ASSERT_NOW(label, ante, cons)
`define ICRC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/icrc_pkg.sv]
`default_nettype none
package icrc_pkg;

    // sizing
    localparam int CHUNK_BYTES   = 240;
    localparam int SEEN_WORDS    = 5;
    localparam int BUFFER_BYTES  = 65536;
    localparam int HEADER_BYTES  = 8;
    localparam int COMMAND_BYTES = 12;

    localparam int SEEN_BITS   = SEEN_WORDS * 32;
    localparam int SEEN_IDX_W  = $clog2(SEEN_BITS);
    localparam int EXP_BYTES_W = 17;
    localparam int OFF_W       = 24;
    localparam int CNT_W       = 16;
    localparam int PCT_W       = 7;
    localparam int NUM_W       = 23;
    localparam int DIV_STEPS   = PCT_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    // packet kinds
    localparam logic [2:0] KIND_START = 3'd0;
    localparam logic [2:0] KIND_DATA  = 3'd1;
    localparam logic [2:0] KIND_END   = 3'd2;
    localparam logic [2:0] KIND_CMD   = 3'd3;

    // command codes
    localparam logic [7:0] CMD_BRIGHTNESS = 8'd0;

    // event codes
    localparam logic [2:0] EV_IGNORED  = 3'd0;
    localparam logic [2:0] EV_STARTED  = 3'd1;
    localparam logic [2:0] EV_FAILED   = 3'd2;
    localparam logic [2:0] EV_TAKEN    = 3'd3;
    localparam logic [2:0] EV_DUP      = 3'd4;
    localparam logic [2:0] EV_ENDED    = 3'd5;
    localparam logic [2:0] EV_BRIGHT   = 3'd6;
    localparam logic [2:0] EV_UNKNOWN  = 3'd7;

    // input tdata layout
    localparam int IN_DATA_W    = 104;
    localparam int IN_PLEN_LSB  = 0;
    localparam int IN_IMG_LSB   = 8;
    localparam int IN_SEQ_LSB   = 24;
    localparam int IN_TOTAL_LSB = 40;
    localparam int IN_BYTES_LSB = 56;
    localparam int IN_CMD_LSB   = 76;
    localparam int IN_ARGC_LSB  = 84;
    localparam int IN_ARG_LSB   = 92;

    // output tdata layout
    localparam int OUT_DATA_W     = 64;
    localparam int OUT_WEN_BIT    = 0;
    localparam int OUT_WOFF_LSB   = 1;
    localparam int OUT_WLEN_LSB   = 17;
    localparam int OUT_DREQ_BIT   = 25;
    localparam int OUT_DBYTES_LSB = 26;
    localparam int OUT_PWMV_BIT   = 42;
    localparam int OUT_PWM_LSB    = 43;
    localparam int OUT_BUSY_BIT   = 51;
    localparam int OUT_DONE_BIT   = 52;
    localparam int OUT_PCT_LSB    = 53;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD,
        S_DIV,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic div_start;
        logic emit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_busy;
        logic out_free;
    } t_dp_status;

    // clamp request to 1..10, active-low level (10-b)*204/9
    function automatic logic [7:0] pwm_from_arg(input logic [7:0] arg);
        logic [3:0] b;
        logic [7:0] lvl;
        begin
            if (arg < 8'd1) begin
                b = 4'd1;
            end else if (arg > 8'd10) begin
                b = 4'd10;
            end else begin
                b = arg[3:0];
            end
            case (b)
                4'd1:    lvl = 8'd204;
                4'd2:    lvl = 8'd181;
                4'd3:    lvl = 8'd158;
                4'd4:    lvl = 8'd136;
                4'd5:    lvl = 8'd113;
                4'd6:    lvl = 8'd90;
                4'd7:    lvl = 8'd68;
                4'd8:    lvl = 8'd45;
                4'd9:    lvl = 8'd22;
                default: lvl = 8'd0;
            endcase
            return lvl;
        end
    endfunction

endpackage
`default_nettype wire

[rtl/image_chunk_reassembly_control.sv]
`default_nettype none
// Channel   Dir  tdata / tuser contents
// s_axis    in   packet header fields, tuser = packet kind
// m_axis    out  write, decode, pwm, status and progress, tuser = event code
//
// One item at a time: from the input transfer to the result in the output
// register an item passes capture, state update, product load, the 7 steps of
// the progress divider, a check that the divider is idle and the result load,
// and the next input transfer is taken only after that result load. The
// divider loop is the longest part of this sequence.
// Reset (i_rst_n low, synchronous) closes any transfer and clears the bitmap.
// A waiting result does not block the next input transfer; that item then
// holds before its result load until the output register is taken.
module image_chunk_reassembly_control
    import icrc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // packet_length, image_number, chunk_sequence, chunk_total, image_bytes,
    // command_code, command_arg_count, command_arg, zero pad
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // packet_kind
    input  wire logic [2:0]            s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // write_enable, write_offset, write_length, decode_request, decode_bytes,
    // pwm_valid, pwm_level, busy_receiving, transfer_done, progress_percent,
    // zero pad
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // event_code
    output logic [2:0]                 m_axis_tuser
);

`include "image_chunk_reassembly_control_macros.svh"

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    icrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    icrc_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .i_kind   (s_axis_tuser),
        .i_data   (s_axis_tdata),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (m_axis_tdata),
        .o_event  (m_axis_tuser)
    );

    // checks
    `ICRC_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `ICRC_ASSERT_NOW(a_no_overwrite, w_cmd.emit, w_status.out_free)
    `ICRC_ASSERT_NOW(a_decode_closes, m_axis_tvalid && m_axis_tdata[OUT_DREQ_BIT], !m_axis_tdata[OUT_BUSY_BIT] && m_axis_tdata[OUT_DONE_BIT])
    `ICRC_ASSERT_NOW(a_pwm_event, m_axis_tvalid && m_axis_tdata[OUT_PWMV_BIT], m_axis_tuser == EV_BRIGHT)
    `ICRC_ASSERT_NOW(a_write_event, m_axis_tvalid && m_axis_tdata[OUT_WEN_BIT], m_axis_tuser == EV_TAKEN)

endmodule
`default_nettype wire

[rtl/icrc_div.sv]
`default_nettype none
// Restoring divider, one quotient bit per cycle, quotient known below 2**PCT_W
module icrc_div
    import icrc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [CNT_W-1:0] i_den,
    output logic                  o_busy,
    output logic [PCT_W-1:0]      o_quot
);

    localparam int DSH_W = CNT_W + PCT_W - 1;

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic [NUM_W-1:0]  r_rem;
    logic [DSH_W-1:0]  r_dsh;
    logic [PCT_W-1:0]  r_quot;
    logic              w_fit;

    assign w_fit  = r_rem >= NUM_W'(r_dsh);
    assign o_busy = r_busy;
    assign o_quot = r_quot;

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= STEP_W'(DIV_STEPS - 1);
        end else if (r_busy) begin
            if (r_step == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_step <= r_step - 1'b1;
            end
        end
    end

    // remainder, shifted divisor and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_dsh  <= {i_den, {(PCT_W-1){1'b0}}};
            r_quot <= '0;
        end else if (r_busy) begin
            if (w_fit) begin
                r_rem <= r_rem - NUM_W'(r_dsh);
            end
            r_quot <= {r_quot[PCT_W-2:0], w_fit};
            r_dsh  <= r_dsh >> 1;
        end
    end

endmodule
`default_nettype wire

[rtl/icrc_dp.sv]
`default_nettype none
// Datapath: packet capture, reassembly state, result build, progress divide
module icrc_dp
    import icrc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_status                 o_status,
    input  wire logic [2:0]            i_kind,
    input  wire logic [IN_DATA_W-1:0]  i_data,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [OUT_DATA_W-1:0]      o_data,
    output logic [2:0]                 o_event
);

    // captured packet
    logic [2:0]       r_kind;
    logic [7:0]       r_plen;
    logic [15:0]      r_img;
    logic [15:0]      r_seq;
    logic [15:0]      r_total;
    logic [19:0]      r_bytes;
    logic [7:0]       r_cmd;
    logic [7:0]       r_argc;
    logic [7:0]       r_arg;
    logic [OFF_W-1:0] r_off;

    // reassembly state
    logic                   r_recv,    n_recv;
    logic                   r_cmpl,    n_cmpl;
    logic                   r_held,    n_held;
    logic [15:0]            r_cur_img, n_cur_img;
    logic [CNT_W-1:0]       r_exp_ch,  n_exp_ch;
    logic [EXP_BYTES_W-1:0] r_exp_by,  n_exp_by;
    logic [CNT_W-1:0]       r_cnt,     n_cnt;
    logic [SEEN_BITS-1:0]   r_seen,    n_seen;

    // result of the update step
    logic [2:0]  r_ev,    n_ev;
    logic        r_wen,   n_wen;
    logic [15:0] r_woff,  n_woff;
    logic [7:0]  r_wlen,  n_wlen;
    logic        r_dreq,  n_dreq;
    logic [15:0] r_dby,   n_dby;
    logic        r_pwmv,  n_pwmv;
    logic [7:0]  r_pwm,   n_pwm;

    // progress
    logic             r_pct_zero;
    logic             r_pct_sat;
    logic             w_div_busy;
    logic [PCT_W-1:0] w_quot;
    logic [PCT_W-1:0] w_pct;
    logic [NUM_W-1:0] w_num;

    // output register
    logic                  r_valid;
    logic [OUT_DATA_W-1:0] r_data;
    logic [2:0]            r_event;

    // scratch of the update step
    logic                   w_match;
    logic                   w_in_map;
    logic                   w_dup;
    logic [EXP_BYTES_W-1:0] w_len;
    logic [CNT_W-1:0]       w_cnt_inc;
    logic                   w_close;
    logic                   w_decode;

    assign o_status.div_busy = w_div_busy;
    assign o_status.out_free = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_event = r_event;

    // capture on the input transfer, offset product registered here
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= i_kind;
            r_plen  <= i_data[IN_PLEN_LSB  +: 8];
            r_img   <= i_data[IN_IMG_LSB   +: 16];
            r_seq   <= i_data[IN_SEQ_LSB   +: 16];
            r_total <= i_data[IN_TOTAL_LSB +: 16];
            r_bytes <= i_data[IN_BYTES_LSB +: 20];
            r_cmd   <= i_data[IN_CMD_LSB   +: 8];
            r_argc  <= i_data[IN_ARGC_LSB  +: 8];
            r_arg   <= i_data[IN_ARG_LSB   +: 8];
            r_off   <= OFF_W'(i_data[IN_SEQ_LSB +: 16]) * OFF_W'(CHUNK_BYTES);
        end
    end

    assign w_match   = r_recv && (r_img == r_cur_img);
    assign w_in_map  = r_seq < 16'(SEEN_BITS);
    assign w_dup     = w_in_map && r_seen[r_seq[SEEN_IDX_W-1:0]];
    assign w_len     = r_exp_by - EXP_BYTES_W'(r_off);
    assign w_cnt_inc = (r_cnt != {CNT_W{1'b1}}) ? r_cnt + 1'b1 : r_cnt;

    // packet decode and state update
    always_comb begin
        n_recv    = r_recv;
        n_cmpl    = r_cmpl;
        n_held    = r_held;
        n_cur_img = r_cur_img;
        n_exp_ch  = r_exp_ch;
        n_exp_by  = r_exp_by;
        n_cnt     = r_cnt;
        n_seen    = r_seen;
        n_ev      = EV_IGNORED;
        n_wen     = 1'b0;
        n_woff    = '0;
        n_wlen    = '0;
        n_pwmv    = 1'b0;
        n_pwm     = '0;
        w_close   = 1'b0;
        w_decode  = 1'b0;
        if (r_plen >= 8'(HEADER_BYTES)) begin
            case (r_kind)
                KIND_START: begin
                    n_cur_img = r_img;
                    n_exp_ch  = r_total;
                    n_cnt     = '0;
                    n_seen    = '0;
                    n_cmpl    = 1'b0;
                    if ({1'b0, r_bytes} > 21'(BUFFER_BYTES)) begin
                        n_exp_by = '0;
                        n_recv   = 1'b0;
                        n_held   = 1'b0;
                        n_ev     = EV_FAILED;
                    end else begin
                        n_exp_by = r_bytes[EXP_BYTES_W-1:0];
                        n_recv   = 1'b1;
                        n_held   = 1'b1;
                        n_ev     = EV_STARTED;
                    end
                end
                KIND_DATA: begin
                    if (w_match) begin
                        if (w_dup) begin
                            n_ev = EV_DUP;
                        end else begin
                            if (w_in_map) begin
                                n_seen[r_seq[SEEN_IDX_W-1:0]] = 1'b1;
                            end
                            n_ev = EV_TAKEN;
                            // no write once the offset reaches the byte total
                            if (r_held && (r_off < OFF_W'(r_exp_by))) begin
                                n_wen  = 1'b1;
                                n_woff = r_off[15:0];
                                n_wlen = (w_len > EXP_BYTES_W'(CHUNK_BYTES)) ?
                                         8'(CHUNK_BYTES) : w_len[7:0];
                            end
                            n_cnt = w_cnt_inc;
                            if ((w_cnt_inc >= r_exp_ch) && r_held) begin
                                w_close  = 1'b1;
                                w_decode = 1'b1;
                            end
                        end
                    end
                end
                KIND_END: begin
                    if (w_match) begin
                        n_ev     = EV_ENDED;
                        w_close  = 1'b1;
                        w_decode = r_cnt >= r_total;
                    end
                end
                KIND_CMD: begin
                    if (r_plen >= 8'(COMMAND_BYTES)) begin
                        if (r_cmd == CMD_BRIGHTNESS) begin
                            if (r_argc >= 8'd1) begin
                                n_ev   = EV_BRIGHT;
                                n_pwmv = 1'b1;
                                n_pwm  = pwm_from_arg(r_arg);
                            end
                        end else begin
                            n_ev = EV_UNKNOWN;
                        end
                    end
                end
                default: begin
                    n_ev = EV_UNKNOWN;
                end
            endcase
        end
        // closing a transfer, decode only with a held buffer
        n_dreq = w_close && w_decode && r_held;
        n_dby  = (n_dreq) ? ((r_exp_by > EXP_BYTES_W'(16'hFFFF)) ?
                 16'hFFFF : r_exp_by[15:0]) : 16'd0;
        if (w_close) begin
            n_cmpl = 1'b1;
            n_recv = 1'b0;
            n_held = 1'b0;
        end
    end

    // reassembly state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recv    <= 1'b0;
            r_cmpl    <= 1'b0;
            r_held    <= 1'b0;
            r_cur_img <= '0;
            r_exp_ch  <= '0;
            r_exp_by  <= '0;
            r_cnt     <= '0;
            r_seen    <= '0;
        end else if (i_cmd.exec) begin
            r_recv    <= n_recv;
            r_cmpl    <= n_cmpl;
            r_held    <= n_held;
            r_cur_img <= n_cur_img;
            r_exp_ch  <= n_exp_ch;
            r_exp_by  <= n_exp_by;
            r_cnt     <= n_cnt;
            r_seen    <= n_seen;
        end
    end

    // result fields of the update step
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_ev   <= n_ev;
            r_wen  <= n_wen;
            r_woff <= n_woff;
            r_wlen <= n_wlen;
            r_dreq <= n_dreq;
            r_dby  <= n_dby;
            r_pwmv <= n_pwmv;
            r_pwm  <= n_pwm;
        end
    end

    // progress: counted*100 / expected, clamped at 100, zero with no chunks expected
    assign w_num = NUM_W'(r_cnt) * NUM_W'(100);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_pct_zero <= r_exp_ch == '0;
            r_pct_sat  <= r_cnt >= r_exp_ch;
        end
    end

    icrc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (r_exp_ch),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    assign w_pct = r_pct_zero ? '0 : (r_pct_sat ? PCT_W'(100) : w_quot);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // result word, fields from the lowest bit up, zero pad on top
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_event <= r_ev;
            r_data  <= {{(OUT_DATA_W-OUT_PCT_LSB-PCT_W){1'b0}}, w_pct, r_cmpl, r_recv,
                        r_pwm, r_pwmv, r_dby, r_dreq, r_wlen, r_woff, r_wen};
        end
    end

endmodule
`default_nettype wire

[rtl/icrc_ctrl.sv]
`default_nettype none
// Controller: sequences capture, update, progress divide and result load
module icrc_ctrl
    import icrc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: n_state = S_LOAD;
            S_LOAD: n_state = S_DIV;
            S_DIV: begin
                if (!i_status.div_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_EXEC: o_cmd.exec      = 1'b1;
            S_LOAD: o_cmd.div_start = 1'b1;
            S_DONE: o_cmd.emit      = i_status.out_free;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

[test/tb_image_chunk_reassembly_control.sv]
`timescale 1ns / 1ps

module tb_image_chunk_reassembly_control;
    import icrc_pkg::*;

    // any packet kind above the command kind is unknown
    localparam logic [2:0] KIND_OTHER = 3'd4;

    typedef struct {
        logic [2:0]  kind;
        logic [7:0]  plen;
        logic [15:0] img;
        logic [15:0] seq;
        logic [15:0] total;
        logic [19:0] bytes;
        logic [7:0]  cmd;
        logic [7:0]  argc;
        logic [7:0]  arg;
    } pkt_t;

    typedef struct {
        logic [2:0]  ev;
        logic        wen;
        logic [15:0] woff;
        logic [7:0]  wlen;
        logic        dreq;
        logic [15:0] dbytes;
        logic        pwmv;
        logic [7:0]  pwm;
        logic        busy;
        logic        done;
        logic [6:0]  pct;
    } res_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // packet_length, image_number, chunk_sequence, chunk_total, image_bytes,
    // command_code, command_arg_count, command_arg, zero pad
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    // packet_kind
    logic [2:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // write_enable, write_offset, write_length, decode_request, decode_bytes,
    // pwm_valid, pwm_level, busy_receiving, transfer_done, progress_percent,
    // zero pad
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // event_code
    logic [2:0]            m_axis_tuser;

    // reassembly state tracked alongside the block
    logic                  rx_open;
    logic                  rx_complete;
    logic                  buf_held;
    logic [15:0]           cur_image;
    logic [15:0]           exp_chunks;
    logic [16:0]           exp_bytes;
    logic [15:0]           chunk_count;
    logic [SEEN_BITS-1:0]  seen_map;

    res_t expected_q[$];
    int   fail_count   = 0;
    int   results_seen = 0;
    bit   idle_on      = 1'b1;
    int   rx_hold      = 0;
    int   rx_stall     = 0;

    image_chunk_reassembly_control DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // close the open transfer, decode only if a buffer is held
    function automatic void close_image(input bit decode, inout res_t r);
        if (decode && buf_held) begin
            r.dreq   = 1'b1;
            r.dbytes = (exp_bytes > 17'd65535) ? 16'hFFFF : exp_bytes[15:0];
        end
        rx_complete = 1'b1;
        rx_open     = 1'b0;
        buf_held    = 1'b0;
    endfunction

    // expected result of one packet header, updates the tracked state
    function automatic res_t predict_packet(input pkt_t p);
        res_t        r;
        bit          dup;
        logic [23:0] offset;
        logic [23:0] remain;
        int          level;
        int          pct;
        r = '{default: '0};
        if (p.plen >= HEADER_BYTES) begin
            case (p.kind)
                KIND_START: begin
                    cur_image   = p.img;
                    exp_chunks  = p.total;
                    chunk_count = '0;
                    seen_map    = '0;
                    rx_complete = 1'b0;
                    if (p.bytes > BUFFER_BYTES) begin
                        exp_bytes = '0;
                        rx_open   = 1'b0;
                        buf_held  = 1'b0;
                        r.ev      = EV_FAILED;
                    end else begin
                        exp_bytes = p.bytes[16:0];
                        rx_open   = 1'b1;
                        buf_held  = 1'b1;
                        r.ev      = EV_STARTED;
                    end
                end
                KIND_DATA: begin
                    if (rx_open && p.img == cur_image) begin
                        dup = 1'b0;
                        // only low sequence numbers are tracked for duplicates
                        if (p.seq < SEEN_BITS) begin
                            if (seen_map[p.seq])
                                dup = 1'b1;
                            else
                                seen_map[p.seq] = 1'b1;
                        end
                        if (dup) begin
                            r.ev = EV_DUP;
                        end else begin
                            r.ev   = EV_TAKEN;
                            offset = p.seq * CHUNK_BYTES;
                            if (buf_held && offset < exp_bytes) begin
                                remain = exp_bytes - offset;
                                if (remain > CHUNK_BYTES)
                                    remain = CHUNK_BYTES;
                                r.wen  = 1'b1;
                                r.woff = offset[15:0];
                                r.wlen = remain[7:0];
                            end
                            if (chunk_count != 16'hFFFF)
                                chunk_count = chunk_count + 16'd1;
                            if (chunk_count >= exp_chunks && buf_held)
                                close_image(1'b1, r);
                        end
                    end
                end
                KIND_END: begin
                    if (rx_open && p.img == cur_image) begin
                        r.ev = EV_ENDED;
                        close_image(chunk_count >= p.total, r);
                    end
                end
                KIND_CMD: begin
                    if (p.plen >= COMMAND_BYTES) begin
                        if (p.cmd == CMD_BRIGHTNESS) begin
                            if (p.argc >= 1) begin
                                level = p.arg;
                                if (level < 1)
                                    level = 1;
                                if (level > 10)
                                    level = 10;
                                r.ev   = EV_BRIGHT;
                                r.pwmv = 1'b1;
                                r.pwm  = 8'((10 - level) * 204 / 9);
                            end
                        end else begin
                            r.ev = EV_UNKNOWN;
                        end
                    end
                end
                default: r.ev = EV_UNKNOWN;
            endcase
        end
        r.busy = rx_open;
        r.done = rx_complete;
        if (exp_chunks != 0) begin
            pct   = int'(chunk_count) * 100 / int'(exp_chunks);
            r.pct = (pct > 100) ? 7'd100 : 7'(pct);
        end
        return r;
    endfunction

    function automatic pkt_t rand_pkt();
        pkt_t p;
        p.kind  = $urandom_range(0, 4);
        p.plen  = $urandom_range(0, 250);
        p.img   = $urandom;
        p.seq   = $urandom;
        p.total = $urandom;
        p.bytes = $urandom_range(0, 20'hFFFFF);
        p.cmd   = $urandom;
        p.argc  = $urandom;
        p.arg   = $urandom;
        return p;
    endfunction

    // header packet, command fields left random
    function automatic pkt_t mk_hdr(input logic [2:0] kind, input logic [7:0] plen,
                                    input logic [15:0] img, input logic [15:0] seq,
                                    input logic [15:0] total, input logic [19:0] bytes);
        pkt_t p;
        p       = rand_pkt();
        p.kind  = kind;
        p.plen  = plen;
        p.img   = img;
        p.seq   = seq;
        p.total = total;
        p.bytes = bytes;
        return p;
    endfunction

    function automatic pkt_t mk_cmd(input logic [7:0] plen, input logic [7:0] code,
                                    input logic [7:0] argc, input logic [7:0] arg);
        pkt_t p;
        p      = rand_pkt();
        p.kind = KIND_CMD;
        p.plen = plen;
        p.cmd  = code;
        p.argc = argc;
        p.arg  = arg;
        return p;
    endfunction

    // mostly brightness, sometimes unknown codes, short or argument-less
    function automatic pkt_t rand_cmd();
        return mk_cmd($urandom_range(0, 250),
                      ($urandom_range(0, 3) == 0) ? 8'($urandom) : CMD_BRIGHTNESS,
                      ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom),
                      ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 11)));
    endfunction

    // one input transfer; valid stays high into the next packet when no gap is drawn
    task automatic send_packet(input pkt_t p);
        logic [IN_DATA_W-1:0] word;
        int                   gap;
        gap  = idle_on ? $urandom_range(0, 16) : 0;
        word = '0;
        word[IN_PLEN_LSB  +: 8]  = p.plen;
        word[IN_IMG_LSB   +: 16] = p.img;
        word[IN_SEQ_LSB   +: 16] = p.seq;
        word[IN_TOTAL_LSB +: 16] = p.total;
        word[IN_BYTES_LSB +: 20] = p.bytes;
        word[IN_CMD_LSB   +: 8]  = p.cmd;
        word[IN_ARGC_LSB  +: 8]  = p.argc;
        word[IN_ARG_LSB   +: 8]  = p.arg;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  = word;
        s_axis_tuser  = p.kind;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_q.push_back(predict_packet(p));
    endtask

    // sender pauses until every pending result is back
    task automatic wait_results_done();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (expected_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_idling(input bit on);
        @(negedge i_clk);
        idle_on = on;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        if (got_v !== want_v) begin
            fail_count++;
            if (fail_count <= 60)
                $display("%0t: result %0d %s expected %0d actual %0d",
                         $time, results_seen, name, want_v, got_v);
        end
    endtask

    // short packets, unknown kind, data and end with no open transfer
    task automatic test_framing_cases();
        send_packet(mk_hdr(KIND_START, 8'd0, 16'd1, 16'd0, 16'd3, 20'd100));
        send_packet(mk_hdr(KIND_START, HEADER_BYTES - 1, 16'd1, 16'd0, 16'd3, 20'd100));
        send_packet(mk_hdr(KIND_OTHER, 8'd250, 16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF));
        send_packet(mk_hdr(KIND_DATA, HEADER_BYTES, 16'd0, 16'd0, 16'd0, 20'd0));
        send_packet(mk_hdr(KIND_END, 8'd250, 16'd0, 16'd0, 16'd0, 20'd0));
    endtask

    // oversize images, duplicates, clipping, writes past the end, decode saturation
    task automatic test_transfer_cases();
        send_packet(mk_hdr(KIND_START, 8'd20, 16'h1234, 16'd0, 16'd4, BUFFER_BYTES + 1));
        send_packet(mk_hdr(KIND_START, 8'd250, 16'hFFFF, 16'd0, 16'd5, 20'hFFFFF));
        send_packet(mk_hdr(KIND_START, 8'd8, 16'hFFFF, 16'd0, 16'd5, 20'd500));
        send_packet(mk_hdr(KIND_DATA, 8'd248, 16'hFFFE, 16'd0, 16'd0, 20'd0));
        send_packet(mk_hdr(KIND_DATA, 8'd248, 16'hFFFF, 16'd0, 16'd0, 20'd0));
        send_packet(mk_hdr(KIND_DATA, 8'd248, 16'hFFFF, 16'd0, 16'd0, 20'd0));
        send_packet(mk_hdr(KIND_DATA, 8'd100, 16'hFFFF, 16'd2, 16'd0, 20'd0));
        send_packet(mk_hdr(KIND_DATA, 8'd100, 16'hFFFF, 16'd3, 16'd0, 20'd0));
        send_packet(mk_hdr(KIND_DATA, 8'd100, 16'hFFFF, 16'hFFFF, 16'd0, 20'd0));
        send_packet(mk_hdr(KIND_DATA, 8'd100, 16'hFFFF, 16'hFFFF, 16'd0, 20'd0));
        send_packet(mk_hdr(KIND_END, 8'd16, 16'hFFFF, 16'd0, 16'd5, 20'd0));
        // closed by end packet before all chunks arrived
        send_packet(mk_hdr(KIND_START, 8'd16, 16'd0, 16'd0, 16'd3, BUFFER_BYTES));
        send_packet(mk_hdr(KIND_END, 8'd16, 16'd0, 16'd0, 16'd3, 20'd0));
        // full buffer: decode count saturates
        send_packet(mk_hdr(KIND_START, 8'd16, 16'd9, 16'd0, 16'd1, BUFFER_BYTES));
        send_packet(mk_hdr(KIND_DATA, 8'd16, 16'd9, 16'd0, 16'd0, 20'd0));
        // zero chunk total
        send_packet(mk_hdr(KIND_START, 8'd16, 16'd5, 16'd0, 16'd0, 20'd0));
        send_packet(mk_hdr(KIND_END, 8'd16, 16'd5, 16'd0, 16'd0, 20'd0));
        send_packet(mk_hdr(KIND_START, 8'd16, 16'd5, 16'd0, 16'd0, 20'd0));
        send_packet(mk_hdr(KIND_DATA, 8'd16, 16'd5, SEEN_BITS - 1, 16'd0, 20'd0));
    endtask

    task automatic test_brightness_cases();
        send_packet(mk_cmd(COMMAND_BYTES - 1, CMD_BRIGHTNESS, 8'd1, 8'd5));
        send_packet(mk_cmd(COMMAND_BYTES, CMD_BRIGHTNESS, 8'd0, 8'd5));
        send_packet(mk_cmd(COMMAND_BYTES, CMD_BRIGHTNESS, 8'd1, 8'd0));
        send_packet(mk_cmd(8'd250, CMD_BRIGHTNESS, 8'd255, 8'd5));
        send_packet(mk_cmd(8'd40, CMD_BRIGHTNESS, 8'd2, 8'd10));
        send_packet(mk_cmd(8'd40, CMD_BRIGHTNESS, 8'd2, 8'd255));
        send_packet(mk_cmd(8'd40, 8'd255, 8'd2, 8'd5));
    endtask

    // transfers, mostly well-formed, with duplicates, strays and interleaved commands
    task automatic test_image_transfers(input int n_images);
        pkt_t        p;
        logic [15:0] img;
        logic [15:0] total;
        logic [15:0] prev_seq;
        logic [15:0] seq_base;
        logic [19:0] bytes;
        logic [15:0] order[12];
        int          span;
        int          n_data;
        int          base;
        int          pick;
        int          tmp;
        img = $urandom;
        for (int k = 0; k < n_images; k++) begin
            if ($urandom_range(0, 3) != 0)
                img = $urandom;
            pick = $urandom_range(0, 9);
            if (pick < 7)
                total = $urandom_range(1, 10);
            else if (pick == 7)
                total = 0;
            else if (pick == 8)
                total = $urandom_range(11, 40);
            else
                total = $urandom;
            base = ((total > 273) ? 273 : total) * CHUNK_BYTES;
            pick = $urandom_range(0, 9);
            if (pick < 6)
                bytes = (base > 239) ? base - $urandom_range(0, 239) : base;
            else if (pick == 6)
                bytes = BUFFER_BYTES;
            else if (pick == 7)
                bytes = $urandom_range(BUFFER_BYTES + 1, 20'hFFFFF);
            else
                bytes = $urandom_range(0, BUFFER_BYTES);
            send_packet(mk_hdr(KIND_START, $urandom_range(HEADER_BYTES, 250), img,
                               $urandom, total, bytes));

            // shuffled chunk order, from a random base up to 150 for big images, which may reach past the tracked range
            span     = (total == 0) ? 1 : ((total > 12) ? 12 : total);
            seq_base = (total > 12) ? $urandom_range(0, 150) : 0;
            for (int j = 0; j < span; j++)
                order[j] = seq_base + j;
            for (int j = span - 1; j > 0; j--) begin
                tmp      = $urandom_range(0, j);
                prev_seq = order[j];
                order[j] = order[tmp];
                order[tmp] = prev_seq;
            end
            n_data   = span + $urandom_range(0, 3);
            prev_seq = order[0];
            for (int j = 0; j < n_data; j++) begin
                pick = $urandom_range(0, 19);
                p = mk_hdr(KIND_DATA, $urandom_range(HEADER_BYTES, 250), img,
                           order[j % span], $urandom, $urandom);
                if (pick == 14 || pick == 15)
                    p.seq = prev_seq;
                else if (pick == 16)
                    p.seq = $urandom_range(SEEN_BITS, 16'hFFFF);
                else if (pick == 17)
                    p.img = img ^ 16'($urandom_range(1, 16'hFFFF));
                else if (pick == 18)
                    p.plen = $urandom_range(0, HEADER_BYTES - 1);
                else if (pick == 19)
                    p = rand_cmd();
                send_packet(p);
                prev_seq = p.seq;
            end

            // end packet: matching, partial total, wrong image or none
            pick = $urandom_range(0, 3);
            if (pick == 1 || pick == 2)
                send_packet(mk_hdr(KIND_END, $urandom_range(HEADER_BYTES, 250), img, $urandom,
                                   (pick == 1) ? total : 16'($urandom_range(0, total)),
                                   $urandom));
            else if (pick == 3)
                send_packet(mk_hdr(KIND_END, $urandom_range(HEADER_BYTES, 250), img ^ 16'd1,
                                   $urandom, total, $urandom));
        end
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_output_stall();
        @(posedge i_clk);
        rx_hold = 300;
        send_packet(mk_hdr(KIND_START, 8'd32, 16'h4242, 16'd0, 16'd20, 20'd4700));
        for (int j = 0; j < 24; j++)
            send_packet(mk_hdr(KIND_DATA, 8'd200, 16'h4242, 16'(j % 21), 16'd0, 20'd0));
        wait_results_done();
    endtask

    // fully random headers, sometimes aimed at the open image
    task automatic test_random_noise(input int n_items);
        pkt_t p;
        for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 3) == 0) begin
                p = rand_cmd();
            end else begin
                p = rand_pkt();
                if ($urandom_range(0, 1) == 0)
                    p.img = cur_image;
            end
            send_packet(p);
        end
    endtask

    // receiver ready: long hold first, then the per-result stall
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                m_axis_tready = 1'b0;
                rx_hold--;
            end else if (rx_stall > 0) begin
                m_axis_tready = 1'b0;
                rx_stall--;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // result check on every output transfer
    always @(posedge i_clk) begin : check_results
        res_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            rx_stall = idle_on ? $urandom_range(0, 16) : 0;
            results_seen++;
            if (expected_q.size() == 0) begin
                fail_count++;
                $display("%0t: result %0d not expected, actual event %0d tdata %h",
                         $time, results_seen, m_axis_tuser, m_axis_tdata);
            end else begin
                want = expected_q.pop_front();
                compare_field("event_code", want.ev, m_axis_tuser);
                compare_field("write_enable", want.wen, m_axis_tdata[OUT_WEN_BIT]);
                compare_field("write_offset", want.woff, m_axis_tdata[OUT_WOFF_LSB +: 16]);
                compare_field("write_length", want.wlen, m_axis_tdata[OUT_WLEN_LSB +: 8]);
                compare_field("decode_request", want.dreq, m_axis_tdata[OUT_DREQ_BIT]);
                compare_field("decode_bytes", want.dbytes, m_axis_tdata[OUT_DBYTES_LSB +: 16]);
                compare_field("pwm_valid", want.pwmv, m_axis_tdata[OUT_PWMV_BIT]);
                compare_field("pwm_level", want.pwm, m_axis_tdata[OUT_PWM_LSB +: 8]);
                compare_field("busy_receiving", want.busy, m_axis_tdata[OUT_BUSY_BIT]);
                compare_field("transfer_done", want.done, m_axis_tdata[OUT_DONE_BIT]);
                compare_field("progress_percent", want.pct, m_axis_tdata[OUT_PCT_LSB +: 7]);
                compare_field("zero pad", 32'd0,
                              m_axis_tdata[OUT_DATA_W-1:OUT_PCT_LSB+7]);
            end
        end
    end

    // run time limit
    initial begin
        #(10_000_000);
        $display("tb_image_chunk_reassembly_control NOT OK");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        rx_open       = 1'b0;
        rx_complete   = 1'b0;
        buf_held      = 1'b0;
        cur_image     = '0;
        exp_chunks    = '0;
        exp_bytes     = '0;
        chunk_count   = '0;
        seen_map      = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_framing_cases();
        test_transfer_cases();
        test_brightness_cases();
        test_image_transfers(90);
        test_output_stall();
        set_idling(1'b0);
        test_image_transfers(20);
        set_idling(1'b1);
        test_random_noise(150);

        wait_results_done();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && expected_q.size() == 0) begin
            $display("tb_image_chunk_reassembly_control OK");
        end else begin
            $display("tb_image_chunk_reassembly_control NOT OK");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/icrc_pkg.sv
rtl/icrc_div.sv
rtl/icrc_dp.sv
rtl/icrc_ctrl.sv
rtl/image_chunk_reassembly_control.sv
test/tb_image_chunk_reassembly_control.sv
